// File: hw/rtl/sffa_pkg.sv
// ----------------------------------------------------------------------------
// sffa_pkg
// Shared types and codes of the subregion first-fit allocator.
// ----------------------------------------------------------------------------
package sffa_pkg;

  localparam int MAX_SUB = 32;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int END_W   = 7;
  localparam int OWNER_W = 8;
  localparam int LEN_W   = 6;
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_OWNER = 2'd3;

  typedef struct packed {
    logic              load;
    logic              count_step;
    logic              scan_step;
    logic              claim;
    logic              locate_step;
    logic              release_run;
    logic              query_step;
    logic              finish;
    logic [STAT_W-1:0] fin_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             size_gt;
    logic             count_full;
    logic             count_zero;
    logic             scan_hit;
    logic             idx_last;
    logic             addr_hit;
    logic             entry_live;
    logic             owner_match;
  } dp_status_t;

endpackage

// File: hw/rtl/subregion_first_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// subregion_first_fit_allocator_top
// First-fit allocator of fixed-size subregions with per-run ownership.
//
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------
// request  | start, busy                | command, size_bytes, address,
//          |                            | owner_id
// result   | done (one-cycle strobe)    | status, result_address, access_mask
// config   | cfg_valid, cfg_ready       | cfg_data (base address)
//
// A transaction is taken when start is high and busy is low; done rises in
// the cycle in which busy falls and stands for that cycle only.
// An allocate rounds the size up to a subregion count in a size loop, then
// scans for the first fitting run; a free looks up the address in a loop,
// and a query walks every subregion.
// Synchronous reset loads the reserved run; no clearing pass is needed.
// ----------------------------------------------------------------------------
module subregion_first_fit_allocator_top
  import sffa_pkg::*;
#(
  parameter int SUBREGS_PER_REGION  = 8,
  parameter int REGION_COUNT        = 4,
  parameter int SUBREGION_BYTES     = 1024,
  parameter int RESERVED_SUBREGIONS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command,
  input  logic [SIZE_W-1:0]   size_bytes,
  input  logic [ADDR_W-1:0]   address,
  input  logic [OWNER_W-1:0]  owner_id,
  output logic                done,
  output logic [STAT_W-1:0]   status,
  output logic [ADDR_W-1:0]   result_address,
  output logic [ADDR_W-1:0]   access_mask,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ADDR_W-1:0]   cfg_data
);

  localparam int NSUB_RAW = SUBREGS_PER_REGION * REGION_COUNT;
  localparam int NSUB     = (NSUB_RAW > MAX_SUB) ? MAX_SUB : NSUB_RAW;
  localparam int NRES     = (RESERVED_SUBREGIONS > NSUB) ? NSUB : RESERVED_SUBREGIONS;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  sffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sffa_datapath #(
    .NSUB            (NSUB),
    .NRES            (NRES),
    .SUBREGION_BYTES (SUBREGION_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid & cfg_ready),
    .cfg_data       (cfg_data),
    .command        (command),
    .size_bytes     (size_bytes),
    .address        (address),
    .owner_id       (owner_id),
    .cmd            (cmd),
    .sts            (sts),
    .done           (done),
    .status         (status),
    .result_address (result_address),
    .access_mask    (access_mask)
  );

endmodule

// File: hw/rtl/sffa_ctrl.sv
// ----------------------------------------------------------------------------
// sffa_ctrl
// Sequencer: steps the datapath through size rounding, first-fit scan,
// address lookup, ownership check and mask build.
// ----------------------------------------------------------------------------
module sffa_ctrl
  import sffa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_COUNT    = 9'b000000100,
    S_SCAN     = 9'b000001000,
    S_CLAIM    = 9'b000010000,
    S_LOCATE   = 9'b000100000,
    S_CHECK    = 9'b001000000,
    S_RELEASE  = 9'b010000000,
    S_QUERY    = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.command)
          CMD_ALLOC: state_next = S_COUNT;
          CMD_FREE:  state_next = S_LOCATE;
          CMD_QUERY: state_next = S_QUERY;
          default: begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STAT_NOT_FOUND;
            state_next     = S_IDLE;
          end
        endcase
      end
      S_COUNT: begin
        if (sts.size_gt) begin
          if (sts.count_full) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STAT_NO_SPACE;
            state_next     = S_IDLE;
          end else begin
            cmd.count_step = 1'b1;
          end
        end else if (sts.count_zero) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_NO_SPACE;
          state_next     = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.scan_step = 1'b1;
          state_next    = S_CLAIM;
        end else if (sts.idx_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_NO_SPACE;
          state_next     = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CLAIM: begin
        cmd.claim      = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_status = STAT_OK;
        state_next     = S_IDLE;
      end
      S_LOCATE: begin
        if (sts.addr_hit) begin
          state_next = S_CHECK;
        end else if (sts.idx_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_NOT_FOUND;
          state_next     = S_IDLE;
        end else begin
          cmd.locate_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (!sts.entry_live) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_NOT_FOUND;
          state_next     = S_IDLE;
        end else if (!sts.owner_match) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_NOT_OWNER;
          state_next     = S_IDLE;
        end else begin
          state_next = S_RELEASE;
        end
      end
      S_RELEASE: begin
        cmd.release_run = 1'b1;
        cmd.finish      = 1'b1;
        cmd.fin_status  = STAT_OK;
        state_next      = S_IDLE;
      end
      S_QUERY: begin
        cmd.query_step = 1'b1;
        if (sts.idx_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_OK;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/sffa_datapath.sv
// ----------------------------------------------------------------------------
// sffa_datapath
// Subregion tables, request registers, scan counters and result registers.
// ----------------------------------------------------------------------------
module sffa_datapath
  import sffa_pkg::*;
#(
  parameter int NSUB            = 32,
  parameter int NRES            = 4,
  parameter int SUBREGION_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic [CMD_W-1:0]    command,
  input  logic [SIZE_W-1:0]   size_bytes,
  input  logic [ADDR_W-1:0]   address,
  input  logic [OWNER_W-1:0]  owner_id,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          sts,
  output logic                done,
  output logic [STAT_W-1:0]   status,
  output logic [ADDR_W-1:0]   result_address,
  output logic [ADDR_W-1:0]   access_mask
);

  localparam int ACC_W = $clog2(NSUB * SUBREGION_BYTES + 1);
  localparam logic [ACC_W-1:0]  SB_ACC   = ACC_W'(SUBREGION_BYTES);
  localparam logic [ADDR_W-1:0] SB_ADDR  = ADDR_W'(SUBREGION_BYTES);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NSUB - 1);
  localparam logic [CNT_W-1:0]  NSUB_CNT = CNT_W'(NSUB);
  localparam logic [END_W-1:0]  NSUB_END = END_W'(NSUB);
  localparam logic [LEN_W-1:0]  NRES_LEN = LEN_W'(NRES);

  logic               used     [MAX_SUB];
  logic               rstart   [MAX_SUB];
  logic [OWNER_W-1:0] owner_tab[MAX_SUB];
  logic [LEN_W-1:0]   len_tab  [MAX_SUB];

  logic [ADDR_W-1:0]  base;
  logic [CMD_W-1:0]   command_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ADDR_W-1:0]  off_r;
  logic [OWNER_W-1:0] owner_r;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   run;
  logic [ACC_W-1:0]   acc;
  logic [IDX_W-1:0]   start_r;
  logic [ADDR_W-1:0]  mask_r;

  logic [CNT_W-1:0]   run_inc;
  logic [CNT_W-1:0]   start_wide;
  logic [END_W-1:0]   claim_end;
  logic [END_W-1:0]   rel_sum;
  logic [END_W-1:0]   rel_clamp;
  logic [END_W-1:0]   rel_end;
  logic [ADDR_W-1:0]  claim_addr;
  logic               query_hit;
  logic [ADDR_W-1:0]  mask_next;

  assign run_inc    = run + CNT_W'(1);
  assign start_wide = CNT_W'(idx) + CNT_W'(1) - cnt;
  assign claim_end  = END_W'(start_r) + END_W'(cnt);
  assign rel_sum    = END_W'(idx) + END_W'(len_tab[idx]);
  assign rel_clamp  = (rel_sum > NSUB_END) ? NSUB_END : rel_sum;
  assign rel_end    = (rel_clamp == END_W'(idx)) ? END_W'(idx) + END_W'(1) : rel_clamp;
  assign claim_addr = base + ADDR_W'(start_r) * SB_ADDR;
  assign query_hit  = used[idx] && (owner_tab[idx] == owner_r);

  always_comb begin
    mask_next = mask_r;
    if (query_hit) begin
      mask_next[idx] = 1'b0;
    end
  end

  always_comb begin
    sts.command     = command_r;
    sts.size_gt     = ADDR_W'(size_r) > ADDR_W'(acc);
    sts.count_full  = (cnt == NSUB_CNT);
    sts.count_zero  = (cnt == '0);
    sts.scan_hit    = !used[idx] && (run_inc == cnt);
    sts.idx_last    = (idx == LAST_IDX);
    sts.addr_hit    = (off_r == ADDR_W'(acc));
    sts.entry_live  = used[idx] && rstart[idx];
    sts.owner_match = (owner_tab[idx] == owner_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_SUB; j++) begin
        used[j]      <= (j < NRES);
        rstart[j]    <= (j == 0) && (NRES > 0);
        owner_tab[j] <= '0;
        len_tab[j]   <= (j < NRES) ? NRES_LEN : '0;
      end
    end else begin
      for (int j = 0; j < MAX_SUB; j++) begin
        if (cmd.claim && (END_W'(j) >= END_W'(start_r)) && (END_W'(j) < claim_end)) begin
          used[j]      <= 1'b1;
          rstart[j]    <= (IDX_W'(j) == start_r);
          owner_tab[j] <= owner_r;
          len_tab[j]   <= LEN_W'(cnt);
        end else if (cmd.release_run && (END_W'(j) >= END_W'(idx)) &&
                     (END_W'(j) < rel_end)) begin
          used[j]      <= 1'b0;
          rstart[j]    <= 1'b0;
          owner_tab[j] <= '0;
          len_tab[j]   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      done <= 1'b0;
      idx  <= '0;
      cnt  <= '0;
      run  <= '0;
      acc  <= '0;
    end else begin
      done <= cmd.finish;
      if (cfg_valid) begin
        base <= cfg_data;
      end
      if (cmd.load) begin
        idx <= '0;
        cnt <= '0;
        run <= '0;
        acc <= '0;
      end
      if (cmd.count_step) begin
        cnt <= cnt + CNT_W'(1);
        acc <= acc + SB_ACC;
      end
      if (cmd.scan_step) begin
        idx <= idx + IDX_W'(1);
        run <= used[idx] ? '0 : run_inc;
      end
      if (cmd.locate_step) begin
        idx <= idx + IDX_W'(1);
        acc <= acc + SB_ACC;
      end
      if (cmd.query_step) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r <= command;
      size_r    <= size_bytes;
      off_r     <= address - base;
      owner_r   <= owner_id;
      mask_r    <= '1;
    end
    if (cmd.scan_step && sts.scan_hit) begin
      start_r <= IDX_W'(start_wide);
    end
    if (cmd.query_step) begin
      mask_r <= mask_next;
    end
    if (cmd.finish) begin
      status         <= cmd.fin_status;
      result_address <= cmd.claim ? claim_addr : '0;
      access_mask    <= (command_r == CMD_QUERY) ? mask_next : '0;
    end
  end

endmodule

// File: hw/rtl/sffa_checker.sv
// ----------------------------------------------------------------------------
// sffa_port_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sffa_port_checker
  import sffa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [STAT_W-1:0]   status,
  input logic [ADDR_W-1:0]   result_address,
  input logic [ADDR_W-1:0]   access_mask
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (result_address == '0))
    else $error("failed transaction returned an address");

  a_mask_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (access_mask != '0)) |-> (status == STAT_OK))
    else $error("access mask on a failed transaction");

endmodule

bind subregion_first_fit_allocator_top sffa_port_checker u_sffa_port_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .result_address (result_address),
  .access_mask    (access_mask)
);

// File: sim/sffa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sffa_checker
// Watches the request, result and base-address channels of the subregion
// first-fit allocator. It keeps its own copy of the used, run-start, owner
// and run-length tables and predicts the reply for each accepted request.
// It then compares every result strobe with the oldest predicted reply.
// ----------------------------------------------------------------------------
module sffa_checker
  import sffa_pkg::*;
#(
  parameter int SUBREGS_PER_REGION  = 8,
  parameter int REGION_COUNT        = 4,
  parameter int SUBREGION_BYTES     = 1024,
  parameter int RESERVED_SUBREGIONS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [SIZE_W-1:0]  size_bytes,
  input  logic [ADDR_W-1:0]  address,
  input  logic [OWNER_W-1:0] owner_id,
  input  logic               done,
  input  logic [STAT_W-1:0]  status,
  input  logic [ADDR_W-1:0]  result_address,
  input  logic [ADDR_W-1:0]  access_mask,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [ADDR_W-1:0]  cfg_data,
  output int                 failures,
  output int                 outstanding
);

  localparam int NSUB = (SUBREGS_PER_REGION * REGION_COUNT > MAX_SUB) ? MAX_SUB :
                        SUBREGS_PER_REGION * REGION_COUNT;
  localparam int NRES = (RESERVED_SUBREGIONS > NSUB) ? NSUB : RESERVED_SUBREGIONS;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] mask;
  } reply_t;

  reply_t             pending_replies[$];
  logic [MAX_SUB-1:0] used_map;
  logic [MAX_SUB-1:0] head_map;
  logic [OWNER_W-1:0] holder [MAX_SUB];
  logic [LEN_W-1:0]   run_len [MAX_SUB];
  logic [ADDR_W-1:0]  base;
  int                 fail_count;

  always @(posedge clk) begin : track
    reply_t            want;
    reply_t            got;
    int                need;
    int                first;
    int                slot;
    int                stop;
    logic              fits;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] owned;
    if (rst) begin
      used_map = '0;
      head_map = '0;
      for (int i = 0; i < MAX_SUB; i++) begin
        holder[i]  = '0;
        run_len[i] = '0;
      end
      for (int i = 0; i < NRES; i++) begin
        used_map[i] = 1'b1;
        run_len[i]  = LEN_W'(NRES);
      end
      head_map[0] = (NRES > 0);
      base = '0;
      pending_replies.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base = cfg_data;
      end

      if (done) begin
        got = '{status, result_address, access_mask};
        if (pending_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result with no transaction pending: status %0d address %h mask %h",
                     $realtime, status, result_address, access_mask);
          end
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status || got.address !== want.address ||
              got.mask !== want.mask) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: status exp %0d got %0d, address exp %h got %h, mask exp %h got %h",
                       $realtime, want.status, got.status, want.address, got.address,
                       want.mask, got.mask);
            end
          end
        end
      end

      if (start && !busy) begin
        want = '0;
        case (command)
          CMD_ALLOC: begin
            need  = (int'(size_bytes) + SUBREGION_BYTES - 1) / SUBREGION_BYTES;
            first = -1;
            if (need != 0 && need <= NSUB) begin
              for (int i = 0; i + need <= NSUB && first < 0; i++) begin
                fits = 1'b1;
                for (int j = i; j < i + need; j++) begin
                  if (used_map[j]) fits = 1'b0;
                end
                if (fits) first = i;
              end
            end
            if (first >= 0) begin
              for (int j = first; j < first + need; j++) begin
                used_map[j] = 1'b1;
                head_map[j] = (j == first);
                holder[j]   = owner_id;
                run_len[j]  = LEN_W'(need);
              end
              want.address = base + ADDR_W'(first * SUBREGION_BYTES);
            end else begin
              want.status = STAT_NO_SPACE;
            end
          end
          CMD_FREE: begin
            offset = address - base;
            slot   = int'(offset / SUBREGION_BYTES);
            if ((offset % SUBREGION_BYTES) != 0 || slot >= NSUB || !used_map[slot] ||
                !head_map[slot]) begin
              want.status = STAT_NOT_FOUND;
            end else if (holder[slot] != owner_id) begin
              want.status = STAT_NOT_OWNER;
            end else begin
              stop = slot + int'(run_len[slot]);
              if (stop > NSUB) stop = NSUB;
              if (stop == slot) stop = slot + 1;
              for (int j = slot; j < stop; j++) begin
                used_map[j] = 1'b0;
                head_map[j] = 1'b0;
                holder[j]   = '0;
                run_len[j]  = '0;
              end
            end
          end
          CMD_QUERY: begin
            owned = '0;
            for (int i = 0; i < NSUB; i++) begin
              if (used_map[i] && holder[i] == owner_id) owned[i] = 1'b1;
            end
            want.mask = ~owned;
          end
          default: begin
            want.status = STAT_NOT_FOUND;
          end
        endcase
        pending_replies.push_back(want);
      end
    end
    failures    <= fail_count;
    outstanding <= pending_replies.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the subregion first-fit allocator. A directed
// run covers zero, oversized and exact-fit allocations, every free error and
// the unused command. Random allocate/free/query traffic follows under
// several base addresses and sender idle rates. The checker instance
// predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
  import sffa_pkg::*;

  localparam int SUBREGS_PER_REGION  = 8;
  localparam int REGION_COUNT        = 4;
  localparam int SUBREGION_BYTES     = 1024;
  localparam int RESERVED_SUBREGIONS = 4;
  localparam int NSUB = (SUBREGS_PER_REGION * REGION_COUNT > MAX_SUB) ? MAX_SUB :
                        SUBREGS_PER_REGION * REGION_COUNT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    int                 idx;
    logic [OWNER_W-1:0] owner;
  } live_run_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [OWNER_W-1:0] owner;
  } taken_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [CMD_W-1:0]   command = '0;
  logic [SIZE_W-1:0]  size_bytes = '0;
  logic [ADDR_W-1:0]  address = '0;
  logic [OWNER_W-1:0] owner_id = '0;
  logic               done;
  logic [STAT_W-1:0]  status;
  logic [ADDR_W-1:0]  result_address;
  logic [ADDR_W-1:0]  access_mask;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ADDR_W-1:0]  cfg_data = '0;
  int                 failures;
  int                 outstanding;

  int                 cycle_count = 0;
  int                 idle_pct = 0;
  logic [ADDR_W-1:0]  cur_base = '0;
  live_run_t          live_runs[$];
  taken_t             taken_q[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  subregion_first_fit_allocator_top #(
    .SUBREGS_PER_REGION  (SUBREGS_PER_REGION),
    .REGION_COUNT        (REGION_COUNT),
    .SUBREGION_BYTES     (SUBREGION_BYTES),
    .RESERVED_SUBREGIONS (RESERVED_SUBREGIONS)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .size_bytes     (size_bytes),
    .address        (address),
    .owner_id       (owner_id),
    .done           (done),
    .status         (status),
    .result_address (result_address),
    .access_mask    (access_mask),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  sffa_checker #(
    .SUBREGS_PER_REGION  (SUBREGS_PER_REGION),
    .REGION_COUNT        (REGION_COUNT),
    .SUBREGION_BYTES     (SUBREGION_BYTES),
    .RESERVED_SUBREGIONS (RESERVED_SUBREGIONS)
  ) monitor_inst (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .size_bytes     (size_bytes),
    .address        (address),
    .owner_id       (owner_id),
    .done           (done),
    .status         (status),
    .result_address (result_address),
    .access_mask    (access_mask),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .failures       (failures),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // track granted runs so that most frees name a live run
  always @(posedge clk) begin : follow_runs
    taken_t head;
    if (!rst) begin
      if (done && taken_q.size() != 0) begin
        head = taken_q.pop_front();
        if (head.cmd == CMD_ALLOC && status == STAT_OK) begin
          live_runs.push_back('{int'((result_address - cur_base) / SUBREGION_BYTES),
                                head.owner});
        end
      end
      if (start && !busy) begin
        taken_q.push_back('{command, owner_id});
      end
    end
  end

  task automatic issue(input logic [CMD_W-1:0] c, input logic [SIZE_W-1:0] s,
                       input logic [ADDR_W-1:0] a, input logic [OWNER_W-1:0] o);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(0, 99) < 80) begin
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        repeat ($urandom_range(4, 40)) @(posedge clk);
      end
    end
    start      <= 1'b1;
    command    <= c;
    size_bytes <= s;
    address    <= a;
    owner_id   <= o;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_base = value;
  endtask

  function automatic logic [OWNER_W-1:0] any_owner();
    if ($urandom_range(0, 99) < 80) return OWNER_W'($urandom_range(0, 3));
    return OWNER_W'($urandom_range(0, 255));
  endfunction

  task automatic random_request();
    int                 pick;
    int                 k;
    logic [CMD_W-1:0]   c;
    logic [SIZE_W-1:0]  s;
    logic [ADDR_W-1:0]  a;
    logic [OWNER_W-1:0] o;
    live_run_t          entry;
    pick = $urandom_range(0, 99);
    s = SIZE_W'($urandom);
    a = $urandom;
    o = any_owner();
    if (pick < 40) begin
      c = CMD_ALLOC;
      k = $urandom_range(0, 99);
      if (k < 5) s = '0;
      else if (k < 15) s = SIZE_W'($urandom);
      else if (k < 30) s = SIZE_W'($urandom_range(1, 8) * SUBREGION_BYTES);
      else s = SIZE_W'($urandom_range(1, 4 * SUBREGION_BYTES));
    end else if (pick < 75) begin
      c = CMD_FREE;
      if (live_runs.size() != 0 && $urandom_range(0, 99) < 75) begin
        k = $urandom_range(0, live_runs.size() - 1);
        entry = live_runs[k];
        a = cur_base + ADDR_W'(entry.idx * SUBREGION_BYTES);
        o = entry.owner;
        live_runs.delete(k);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            if (live_runs.size() != 0) begin
              entry = live_runs[$urandom_range(0, live_runs.size() - 1)];
              a = cur_base + ADDR_W'(entry.idx * SUBREGION_BYTES);
              o = entry.owner + 1'b1;
            end
          end
          1: a = cur_base + ADDR_W'($urandom_range(0, NSUB - 1) * SUBREGION_BYTES +
                                    $urandom_range(1, SUBREGION_BYTES - 1));
          2: a = cur_base + ADDR_W'($urandom_range(0, NSUB + 8) * SUBREGION_BYTES);
          default: ;
        endcase
      end
    end else if (pick < 96) begin
      c = CMD_QUERY;
      if (live_runs.size() != 0 && $urandom_range(0, 1) == 1) begin
        o = live_runs[$urandom_range(0, live_runs.size() - 1)].owner;
      end
    end else begin
      c = CMD_UNUSED;
    end
    issue(c, s, a, o);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_base('0);
    issue(CMD_QUERY, '0, '0, 8'd0);
    issue(CMD_ALLOC, '0, '0, 8'd1);
    issue(CMD_ALLOC, 16'hFFFF, '0, 8'd1);
    issue(CMD_ALLOC, 16'd1, '0, 8'hFF);
    issue(CMD_ALLOC, SIZE_W'(SUBREGION_BYTES), '0, 8'd1);
    issue(CMD_ALLOC, SIZE_W'(SUBREGION_BYTES + 1), '0, 8'd2);
    issue(CMD_ALLOC, SIZE_W'(28 * SUBREGION_BYTES), '0, 8'd3);
    issue(CMD_ALLOC, SIZE_W'(24 * SUBREGION_BYTES), '0, 8'd3);
    issue(CMD_ALLOC, 16'd1, '0, 8'd1);
    issue(CMD_QUERY, '0, '0, 8'd3);
    issue(CMD_QUERY, '0, '0, 8'hFF);
    issue(CMD_FREE, '0, ADDR_W'(5 * SUBREGION_BYTES + 1), 8'd1);
    issue(CMD_FREE, '0, ADDR_W'(NSUB * SUBREGION_BYTES), 8'd1);
    issue(CMD_FREE, '0, ADDR_W'(7 * SUBREGION_BYTES), 8'd2);
    issue(CMD_FREE, '0, ADDR_W'(6 * SUBREGION_BYTES), 8'd1);
    issue(CMD_FREE, '0, ADDR_W'(6 * SUBREGION_BYTES), 8'd2);
    issue(CMD_FREE, '0, '0, 8'd0);
    issue(CMD_FREE, '0, '0, 8'd0);
    issue(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    issue(CMD_FREE, '0, 32'hFFFF_FFFF, 8'hFF);
    issue(CMD_FREE, '0, ADDR_W'(4 * SUBREGION_BYTES), 8'hFF);
    issue(CMD_FREE, '0, ADDR_W'(5 * SUBREGION_BYTES), 8'd1);
    issue(CMD_FREE, '0, ADDR_W'(8 * SUBREGION_BYTES), 8'd3);
    issue(CMD_ALLOC, SIZE_W'(NSUB * SUBREGION_BYTES), '0, 8'h5A);
    issue(CMD_QUERY, '0, '0, 8'h5A);
    issue(CMD_FREE, '0, '0, 8'h5A);

    write_base(32'hFFFF_F000);
    live_runs.delete();
    idle_pct = 17;
    repeat (420) random_request();

    write_base(32'hFFFF_FFFF);
    idle_pct = 50;
    repeat (420) random_request();

    write_base($urandom);
    idle_pct = 0;
    repeat (210) random_request();

    write_base('0);
    repeat (210) random_request();

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sffa_pkg.sv
hw/rtl/sffa_ctrl.sv
hw/rtl/sffa_datapath.sv
hw/rtl/subregion_first_fit_allocator_top.sv
hw/rtl/sffa_checker.sv
sim/sffa_checker.sv
sim/testbench.sv
